@@ sv/cbb_pkg.sv @@
`default_nettype none

package cbb_pkg;

  localparam int MAX_DEPTH_DEFAULT = 255;
  localparam int MAX_SCAN_DEFAULT  = 65536;

  localparam int CHAR_W   = 8;
  localparam int OFFSET_W = 16;
  localparam int MODE_W   = 4;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic REG_SCAN_BACKWARD = 1'b0;

  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_DQUOTE   = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE   = 8'h27;
  localparam logic [CHAR_W-1:0] CH_LROUND   = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RROUND   = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_LSQUARE  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BACKSL   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_RSQUARE  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LCURLY   = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RCURLY   = 8'h7D;

  localparam logic [MODE_W-1:0] MODE_NORMAL  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SLASH   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 4'd2;
  localparam logic [MODE_W-1:0] MODE_STAR    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_DQUOTE  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SQUOTE  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_ESCAPE  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_BAD     = 4'd7;
  localparam logic [MODE_W-1:0] MODE_START   = 4'd8;

  localparam logic [1:0] OUTCOME_BALANCED  = 2'd0;
  localparam logic [1:0] OUTCOME_UNMATCHED = 2'd1;
  localparam logic [1:0] OUTCOME_BAD       = 2'd2;
  localparam logic [1:0] OUTCOME_NO_END    = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              first_of_search;
    logic              last_in_range;
  } src_item_t;

  typedef struct packed {
    logic [1:0]          outcome;
    logic [CHAR_W-1:0]   deciding_char;
    logic [OFFSET_W-1:0] char_offset;
  } res_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] mode_before_escape;
    logic              run;
    logic              square_up;
    logic              square_down;
    logic              curly_up;
    logic              curly_down;
    logic              round_up;
    logic              round_down;
  } feed_t;

endpackage

`default_nettype wire

@@ sv/c_bracket_balance_scanner.sv @@
// C bracket balance scanner.
// Source characters arrive on the src channel (valid/ready), one item per
// character in scan order, with first_of_search opening a new search and
// last_in_range closing the window. Each search gives at most one item on
// the res channel (valid/ready): the outcome, the deciding character and
// its offset within the search. Direction is set by the scan_backward
// register on the APB port, which the user must write only while the block
// is idle; the block itself does not enforce this. An accepted item waits
// in the input register, is evaluated from there, and its result is
// registered when the input register moves on. One item per cycle
// is sustained: the input register moves on whenever the item produces no
// result or the result register is free or being emptied, so one more item
// is taken while a result waits.
// When the receiver stalls, the result holds; items that give no result
// still pass, and src_ready drops once an item that gives a result waits
// in the input register. Reset empties both stages, clears scan_backward
// and leaves the scanner idle: items without first_of_search are dropped
// without a result until a search starts.
`default_nettype none

module c_bracket_balance_scanner #(
  parameter int MAX_DEPTH = cbb_pkg::MAX_DEPTH_DEFAULT,
  parameter int MAX_SCAN  = cbb_pkg::MAX_SCAN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       src_valid,
  output logic                       src_ready,
  input  cbb_pkg::src_item_t         src_item,
  output logic                       res_valid,
  input  logic                       res_ready,
  output cbb_pkg::res_item_t         res_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cbb_pkg::ADDR_W-1:0] paddr,
  input  logic [cbb_pkg::DATA_W-1:0] pwdata,
  output logic [cbb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int DW = $clog2(MAX_DEPTH + 2) + 1;
  localparam int CW = $clog2(MAX_SCAN);
  localparam logic signed [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);
  localparam logic [CW-1:0] SCAN_LAST = CW'(MAX_SCAN - 1);

  logic scan_backward;
  logic s1_valid;
  cbb_pkg::src_item_t s1_item;
  logic s1_fire;

  logic [cbb_pkg::MODE_W-1:0] mode;
  logic [cbb_pkg::MODE_W-1:0] mode_before_escape;
  logic signed [DW-1:0] square_depth;
  logic signed [DW-1:0] curly_depth;
  logic signed [DW-1:0] round_depth;
  logic backslash_parity;
  logic [cbb_pkg::CHAR_W-1:0] held_char;
  logic [cbb_pkg::OFFSET_W-1:0] held_offset;
  logic [CW-1:0] consumed_count;
  logic search_finished;

  logic [cbb_pkg::MODE_W-1:0] cur_mode;
  logic [cbb_pkg::MODE_W-1:0] cur_mbe;
  logic signed [DW-1:0] cur_square;
  logic signed [DW-1:0] cur_curly;
  logic signed [DW-1:0] cur_round;
  logic cur_parity;
  logic [cbb_pkg::CHAR_W-1:0] cur_held;
  logic [cbb_pkg::OFFSET_W-1:0] cur_hoff;
  logic [CW-1:0] cur_count;
  logic cur_finished;

  logic [cbb_pkg::MODE_W-1:0] mode_next;
  logic [cbb_pkg::MODE_W-1:0] mode_before_escape_next;
  logic signed [DW-1:0] square_depth_next;
  logic signed [DW-1:0] curly_depth_next;
  logic signed [DW-1:0] round_depth_next;
  logic backslash_parity_next;
  logic [cbb_pkg::CHAR_W-1:0] held_char_next;
  logic [cbb_pkg::OFFSET_W-1:0] held_offset_next;
  logic [CW-1:0] consumed_count_next;
  logic search_finished_next;

  logic [cbb_pkg::CHAR_W-1:0] x;
  logic [cbb_pkg::OFFSET_W-1:0] idx16;
  logic last;
  logic use_feed;
  logic produce;
  logic bad;
  cbb_pkg::feed_t fd;
  cbb_pkg::res_item_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_backward <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == cbb_pkg::REG_SCAN_BACKWARD) begin
      scan_backward <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == cbb_pkg::REG_SCAN_BACKWARD) ?
                  {{(cbb_pkg::DATA_W-1){1'b0}}, scan_backward} : '0;

  // a new search starts from cleared state
  always_comb begin
    if (s1_item.first_of_search) begin
      cur_mode = cbb_pkg::MODE_START;
      cur_mbe = cbb_pkg::MODE_NORMAL;
      cur_square = '0;
      cur_curly = '0;
      cur_round = '0;
      cur_parity = 1'b0;
      cur_held = '0;
      cur_hoff = '0;
      cur_count = '0;
      cur_finished = 1'b0;
    end else begin
      cur_mode = mode;
      cur_mbe = mode_before_escape;
      cur_square = square_depth;
      cur_curly = curly_depth;
      cur_round = round_depth;
      cur_parity = backslash_parity;
      cur_held = held_char;
      cur_hoff = held_offset;
      cur_count = consumed_count;
      cur_finished = search_finished;
    end
  end

  assign x = s1_item.character;
  assign idx16 = cbb_pkg::OFFSET_W'(cur_count);
  assign last = s1_item.last_in_range || (cur_count == SCAN_LAST);

  cbb_feed u_feed (
    .character          (scan_backward ? cur_held : x),
    .mode               (cur_mode),
    .mode_before_escape (cur_mbe),
    .backward           (scan_backward),
    .square_busy        (cur_square != '0),
    .round_busy         (cur_round != '0),
    .step               (fd)
  );

  always_comb begin
    mode_next = cur_mode;
    mode_before_escape_next = cur_mbe;
    square_depth_next = cur_square;
    curly_depth_next = cur_curly;
    round_depth_next = cur_round;
    backslash_parity_next = cur_parity;
    held_char_next = cur_held;
    held_offset_next = cur_hoff;
    consumed_count_next = cur_count;
    search_finished_next = cur_finished;
    use_feed = 1'b0;
    produce = 1'b0;
    bad = 1'b0;
    result.outcome = cbb_pkg::OUTCOME_NO_END;
    result.deciding_char = x;
    result.char_offset = idx16;

    if (!cur_finished) begin
      consumed_count_next = cur_count + 1'b1;
      if (!scan_backward) begin
        use_feed = 1'b1;
      end else if (cur_mode == cbb_pkg::MODE_START) begin
        mode_next = cbb_pkg::MODE_NORMAL;
        held_char_next = x;
        held_offset_next = idx16;
      end else if (x == cbb_pkg::CH_BACKSL && cur_mode != cbb_pkg::MODE_COMMENT &&
                   cur_mode != cbb_pkg::MODE_SLASH) begin
        backslash_parity_next = ~cur_parity;
      end else begin
        if (cur_parity) begin
          backslash_parity_next = 1'b0;
        end else begin
          use_feed = 1'b1;
          result.deciding_char = cur_held;
          result.char_offset = cur_hoff;
        end
        held_char_next = x;
        held_offset_next = idx16;
      end

      if (use_feed) begin
        mode_next = fd.mode;
        mode_before_escape_next = fd.mode_before_escape;
        square_depth_next = cur_square + DW'(fd.square_up) - DW'(fd.square_down);
        curly_depth_next = cur_curly + DW'(fd.curly_up) - DW'(fd.curly_down);
        round_depth_next = cur_round + DW'(fd.round_up) - DW'(fd.round_down);
        bad = (fd.mode == cbb_pkg::MODE_BAD) || (square_depth_next > DEPTH_MAX) ||
              (curly_depth_next > DEPTH_MAX) || (round_depth_next > DEPTH_MAX);
      end

      if (use_feed && fd.run) begin
        if (bad) begin
          produce = 1'b1;
          result.outcome = cbb_pkg::OUTCOME_BAD;
        end else if (square_depth_next[DW-1] || curly_depth_next[DW-1] ||
                     round_depth_next[DW-1]) begin
          produce = 1'b1;
          result.outcome = cbb_pkg::OUTCOME_UNMATCHED;
        end else if (square_depth_next == '0 && curly_depth_next == '0 &&
                     round_depth_next == '0) begin
          produce = 1'b1;
          result.outcome = cbb_pkg::OUTCOME_BALANCED;
        end
      end

      if (!produce && last) begin
        produce = 1'b1;
        result.outcome = cbb_pkg::OUTCOME_NO_END;
        result.deciding_char = x;
        result.char_offset = idx16;
      end

      if (produce) begin
        search_finished_next = 1'b1;
      end
    end
  end

  assign s1_fire = s1_valid && (!produce || !res_valid || res_ready);
  assign src_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (src_ready) begin
      s1_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_ready && src_valid) begin
      s1_item <= src_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cbb_pkg::MODE_START;
      mode_before_escape <= cbb_pkg::MODE_NORMAL;
      square_depth <= '0;
      curly_depth <= '0;
      round_depth <= '0;
      backslash_parity <= 1'b0;
      held_char <= '0;
      held_offset <= '0;
      consumed_count <= '0;
      search_finished <= 1'b1;
    end else if (s1_fire) begin
      mode <= mode_next;
      mode_before_escape <= mode_before_escape_next;
      square_depth <= square_depth_next;
      curly_depth <= curly_depth_next;
      round_depth <= round_depth_next;
      backslash_parity <= backslash_parity_next;
      held_char <= held_char_next;
      held_offset <= held_offset_next;
      consumed_count <= consumed_count_next;
      search_finished <= search_finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && produce) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      res_item <= result;
    end
  end

endmodule

`default_nettype wire

@@ sv/cbb_feed.sv @@
`default_nettype none

module cbb_feed (
  input  logic [cbb_pkg::CHAR_W-1:0] character,
  input  logic [cbb_pkg::MODE_W-1:0] mode,
  input  logic [cbb_pkg::MODE_W-1:0] mode_before_escape,
  input  logic                       backward,
  input  logic                       square_busy,
  input  logic                       round_busy,
  output cbb_pkg::feed_t             step
);

  logic go;
  logic open_sq;
  logic close_sq;
  logic open_cu;
  logic close_cu;
  logic open_rd;
  logic close_rd;

  always_comb begin
    step = '0;
    step.mode = mode;
    step.mode_before_escape = mode_before_escape;
    go = 1'b0;
    open_sq = 1'b0;
    close_sq = 1'b0;
    open_cu = 1'b0;
    close_cu = 1'b0;
    open_rd = 1'b0;
    close_rd = 1'b0;

    unique case (mode) inside
      cbb_pkg::MODE_SLASH: begin
        if (character == cbb_pkg::CH_STAR) begin
          step.mode = cbb_pkg::MODE_COMMENT;
        end else begin
          go = 1'b1;
        end
      end
      cbb_pkg::MODE_STAR: begin
        if (character == cbb_pkg::CH_SLASH) begin
          step.mode = cbb_pkg::MODE_NORMAL;
          step.run = 1'b1;
        end else if (character == cbb_pkg::CH_STAR) begin
          step.mode = cbb_pkg::MODE_STAR;
        end else begin
          step.mode = cbb_pkg::MODE_COMMENT;
        end
      end
      cbb_pkg::MODE_COMMENT: begin
        if (character == cbb_pkg::CH_STAR) begin
          step.mode = cbb_pkg::MODE_STAR;
        end
      end
      cbb_pkg::MODE_DQUOTE, cbb_pkg::MODE_SQUOTE: begin
        if (character == cbb_pkg::CH_NEWLINE) begin
          step.mode = cbb_pkg::MODE_BAD;
          step.run = 1'b1;
        end else if (character == cbb_pkg::CH_BACKSL) begin
          step.mode_before_escape = mode;
          step.mode = cbb_pkg::MODE_ESCAPE;
        end else if ((character == cbb_pkg::CH_DQUOTE && mode == cbb_pkg::MODE_DQUOTE) ||
                     (character == cbb_pkg::CH_SQUOTE && mode == cbb_pkg::MODE_SQUOTE)) begin
          step.mode = cbb_pkg::MODE_NORMAL;
          step.run = 1'b1;
        end
      end
      cbb_pkg::MODE_ESCAPE: begin
        step.mode = mode_before_escape;
      end
      default: begin
        go = 1'b1;
      end
    endcase

    if (go) begin
      step.mode = cbb_pkg::MODE_NORMAL;
      step.run = 1'b1;
      case (character)
        cbb_pkg::CH_LSQUARE: open_sq = 1'b1;
        cbb_pkg::CH_RSQUARE: close_sq = 1'b1;
        cbb_pkg::CH_LROUND:  open_rd = 1'b1;
        cbb_pkg::CH_RROUND:  close_rd = 1'b1;
        cbb_pkg::CH_LCURLY, cbb_pkg::CH_RCURLY: begin
          open_cu = (character == cbb_pkg::CH_LCURLY);
          close_cu = (character == cbb_pkg::CH_RCURLY);
          if (round_busy || square_busy) begin
            step.mode = cbb_pkg::MODE_BAD;
          end
        end
        cbb_pkg::CH_SEMI: begin
          if (square_busy) begin
            step.mode = cbb_pkg::MODE_BAD;
          end
        end
        cbb_pkg::CH_DQUOTE: begin
          step.mode = cbb_pkg::MODE_DQUOTE;
          step.run = 1'b0;
        end
        cbb_pkg::CH_SQUOTE: begin
          step.mode = cbb_pkg::MODE_SQUOTE;
          step.run = 1'b0;
        end
        cbb_pkg::CH_BACKSL: begin
          step.mode_before_escape = cbb_pkg::MODE_NORMAL;
          step.mode = cbb_pkg::MODE_ESCAPE;
          step.run = 1'b0;
        end
        cbb_pkg::CH_SLASH: begin
          step.mode = cbb_pkg::MODE_SLASH;
          step.run = 1'b0;
        end
        default: ;
      endcase
    end

    // backward scan counts closers up and openers down
    step.square_up   = backward ? close_sq : open_sq;
    step.square_down = backward ? open_sq  : close_sq;
    step.curly_up    = backward ? close_cu : open_cu;
    step.curly_down  = backward ? open_cu  : close_cu;
    step.round_up    = backward ? close_rd : open_rd;
    step.round_down  = backward ? open_rd  : close_rd;
  end

endmodule

`default_nettype wire

@@ sv/cbb_checker.sv @@
`default_nettype none

module cbb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       src_valid,
  input logic                       src_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input cbb_pkg::res_item_t         res_item,
  input logic                       pready
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

  a_res_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(src_valid && src_ready, 2))
    else $error("result without an item two cycles before");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind c_bracket_balance_scanner cbb_checker u_cbb_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_ready (src_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_item  (res_item),
  .pready    (pready)
);

`default_nettype wire

@@ tb/sv/tb_c_bracket_balance_scanner.sv @@
module tb_c_bracket_balance_scanner;
  import cbb_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam logic [ADDR_W-1:0] SCAN_DIR_ADDR = ADDR_W'(4 * REG_SCAN_BACKWARD);

  typedef logic [CHAR_W-1:0] text_t[$];

  logic clk;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  wire src_ready;
  src_item_t src_item = '0;
  wire res_valid;
  logic res_ready = 1'b0;
  res_item_t res_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  wire [DATA_W-1:0] prdata;
  wire pready;

  c_bracket_balance_scanner dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item(src_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_item(res_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // scanner state as the block should hold it
  logic cfg_backward = 1'b0;
  logic [MODE_W-1:0] lex_mode = MODE_START;
  logic [MODE_W-1:0] lex_mode_saved = MODE_NORMAL;
  int sq_level = 0;
  int cu_level = 0;
  int ro_level = 0;
  bit esc_odd = 1'b0;
  logic [CHAR_W-1:0] lag_char = '0;
  int lag_index = 0;
  int char_count = 0;
  bit search_idle = 1'b1;
  bit item_ignored;

  res_item_t pending_verdicts[$];
  text_t text_buf;
  int errors = 0;
  int scanned_total = 0;
  int src_idle_pct = 0;
  int res_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit lex_step(input logic [CHAR_W-1:0] c, input int d);
    case (lex_mode)
      MODE_SLASH: begin
        if (c == CH_STAR) begin
          lex_mode = MODE_COMMENT;
          return 1'b0;
        end
        lex_mode = MODE_NORMAL;
      end
      MODE_NORMAL: ;
      MODE_STAR: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_NORMAL;
          return 1'b1;
        end
        lex_mode = (c == CH_STAR) ? MODE_STAR : MODE_COMMENT;
        return 1'b0;
      end
      MODE_COMMENT: begin
        if (c == CH_STAR) lex_mode = MODE_STAR;
        return 1'b0;
      end
      MODE_DQUOTE, MODE_SQUOTE: begin
        if (c == CH_NEWLINE) begin
          lex_mode = MODE_BAD;
          return 1'b1;
        end
        if (c == CH_BACKSL) begin
          lex_mode_saved = lex_mode;
          lex_mode = MODE_ESCAPE;
          return 1'b0;
        end
        if ((c == CH_DQUOTE && lex_mode == MODE_DQUOTE) ||
            (c == CH_SQUOTE && lex_mode == MODE_SQUOTE)) begin
          lex_mode = MODE_NORMAL;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_ESCAPE: begin
        lex_mode = lex_mode_saved;
        return 1'b0;
      end
      default: lex_mode = MODE_NORMAL;
    endcase
    case (c)
      CH_LSQUARE: sq_level += d;
      CH_RSQUARE: sq_level -= d;
      CH_LROUND: ro_level += d;
      CH_RROUND: ro_level -= d;
      CH_LCURLY, CH_RCURLY: begin
        cu_level += (c == CH_LCURLY) ? d : -d;
        if (ro_level != 0 || sq_level != 0) lex_mode = MODE_BAD;
      end
      CH_SEMI: if (sq_level != 0) lex_mode = MODE_BAD;
      CH_DQUOTE: begin
        lex_mode = MODE_DQUOTE;
        return 1'b0;
      end
      CH_SQUOTE: begin
        lex_mode = MODE_SQUOTE;
        return 1'b0;
      end
      CH_BACKSL: begin
        lex_mode_saved = MODE_NORMAL;
        lex_mode = MODE_ESCAPE;
        return 1'b0;
      end
      CH_SLASH: begin
        lex_mode = MODE_SLASH;
        return 1'b0;
      end
      default: ;
    endcase
    if (sq_level > MAX_DEPTH_DEFAULT || cu_level > MAX_DEPTH_DEFAULT ||
        ro_level > MAX_DEPTH_DEFAULT) lex_mode = MODE_BAD;
    return 1'b1;
  endfunction

  function automatic int end_verdict();
    if (lex_mode == MODE_BAD) return int'(OUTCOME_BAD);
    if (sq_level < 0 || cu_level < 0 || ro_level < 0) return int'(OUTCOME_UNMATCHED);
    if (sq_level == 0 && cu_level == 0 && ro_level == 0) return int'(OUTCOME_BALANCED);
    return -1;
  endfunction

  function automatic bit predict_scan(input src_item_t it, output res_item_t r);
    int idx;
    logic [CHAR_W-1:0] dc;
    int doff;
    int verdict;
    bit tested;
    bit at_end;
    r = '0;
    dc = '0;
    doff = 0;
    verdict = -1;
    tested = 1'b0;
    at_end = it.last_in_range;
    item_ignored = 1'b0;
    if (it.first_of_search) begin
      lex_mode = MODE_START;
      lex_mode_saved = MODE_NORMAL;
      sq_level = 0;
      cu_level = 0;
      ro_level = 0;
      esc_odd = 1'b0;
      lag_char = '0;
      lag_index = 0;
      char_count = 0;
      search_idle = 1'b0;
    end
    if (search_idle) begin
      item_ignored = 1'b1;
      return 1'b0;
    end
    idx = char_count;
    char_count++;
    if (char_count >= MAX_SCAN_DEFAULT) at_end = 1'b1;
    if (!cfg_backward) begin
      tested = lex_step(it.character, 1);
      dc = it.character;
      doff = idx;
    end else if (lex_mode == MODE_START) begin
      lex_mode = MODE_NORMAL;
      lag_char = it.character;
      lag_index = idx;
    end else if (it.character == CH_BACKSL && lex_mode != MODE_COMMENT &&
                 lex_mode != MODE_SLASH) begin
      esc_odd = ~esc_odd;
    end else begin
      if (esc_odd) begin
        esc_odd = 1'b0;
      end else begin
        tested = lex_step(lag_char, -1);
        dc = lag_char;
        doff = lag_index;
      end
      lag_char = it.character;
      lag_index = idx;
    end
    if (tested) verdict = end_verdict();
    if (verdict < 0) begin
      if (!at_end) return 1'b0;
      verdict = int'(OUTCOME_NO_END);
      dc = it.character;
      doff = idx;
    end
    search_idle = 1'b1;
    r.outcome = verdict[1:0];
    r.deciding_char = dc;
    r.char_offset = doff[OFFSET_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] c, input bit opens, input bit closes);
    src_item_t it;
    res_item_t r;
    it.character = c;
    it.first_of_search = opens;
    it.last_in_range = closes;
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item <= it;
    @(posedge clk);
    while (!src_ready) @(posedge clk);
    if (predict_scan(it, r)) pending_verdicts.push_back(r);
    if (!item_ignored) scanned_total++;
  endtask

  task automatic send_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, mark_last && i == s.len() - 1);
  endtask

  task automatic send_run(input logic [CHAR_W-1:0] c, input int n);
    for (int i = 0; i < n; i++) send_char(c, i == 0, 1'b0);
  endtask

  task automatic wait_quiet();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == SCAN_DIR_ADDR) cfg_backward = value[0];
  endtask

  // receiver: random back-pressure, long hold on request, result check
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result outcome %0d char %h offset %0d", $time,
                   res_item.outcome, res_item.deciding_char, res_item.char_offset);
        end else begin
          res_item_t want;
          want = pending_verdicts.pop_front();
          if (res_item.outcome !== want.outcome ||
              res_item.deciding_char !== want.deciding_char ||
              res_item.char_offset !== want.char_offset) begin
            errors++;
            $display("%0t: mismatch expected outcome %0d char %h offset %0d, %s %0d %h %0d",
                     $time, want.outcome, want.deciding_char, want.char_offset, "actual",
                     res_item.outcome, res_item.deciding_char, res_item.char_offset);
          end
        end
      end
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99) >= res_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (res_valid && res_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic gen_quoted(input logic [CHAR_W-1:0] q);
    string pool;
    pool = "a ({})['\"\\;/*";
    text_buf.push_back(q);
    repeat ($urandom_range(0, 4)) begin
      text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      if (text_buf[$] == CH_BACKSL) text_buf.push_back(pool[$urandom_range(0, pool.len() - 1)]);
    end
    if ($urandom_range(19) == 0) text_buf.push_back(CH_NEWLINE);
    text_buf.push_back(q);
  endtask

  task automatic gen_body(input int lvl);
    string ops;
    string inner;
    ops = " +-*/;,\n";
    inner = "a*/ ()\\";
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 11))
        0, 1: repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(97, 122)));
        2, 3: if (lvl < 4) begin
          text_buf.push_back(CH_LROUND);
          gen_body(lvl + 1);
          text_buf.push_back(CH_RROUND);
        end
        4: if (lvl < 4) begin
          text_buf.push_back(CH_LSQUARE);
          gen_body(lvl + 1);
          text_buf.push_back(CH_RSQUARE);
        end
        5: if (lvl < 3) begin
          text_buf.push_back(CH_LCURLY);
          gen_body(lvl + 1);
          text_buf.push_back(CH_SEMI);
          text_buf.push_back(CH_RCURLY);
        end
        6: gen_quoted(CH_DQUOTE);
        7: gen_quoted(CH_SQUOTE);
        8: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_STAR);
          repeat ($urandom_range(0, 4)) text_buf.push_back(inner[$urandom_range(0, inner.len() - 1)]);
          text_buf.push_back(CH_STAR);
          text_buf.push_back(CH_SLASH);
        end
        9: text_buf.push_back(ops[$urandom_range(0, ops.len() - 1)]);
        10: begin
          text_buf.push_back(CH_BACKSL);
          text_buf.push_back(8'($urandom_range(32, 126)));
        end
        default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_random_search();
    int kind;
    int last_pos;
    string openers;
    string closers;
    openers = "([{";
    closers = ")]}";
    kind = $urandom_range(0, 2);
    text_buf.delete();
    text_buf.push_back(openers[kind]);
    gen_body(1);
    text_buf.push_back(closers[kind]);
    if (cfg_backward) begin
      text_buf.reverse();
      text_buf.push_back(8'($urandom_range(32, 126)));
    end
    if ($urandom_range(7) == 0)
      text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(9) == 0 && text_buf.size() > 2)
      text_buf = text_buf[0:$urandom_range(1, text_buf.size() - 2)];
    case ($urandom_range(0, 5))
      0: last_pos = $urandom_range(0, text_buf.size() - 1);
      1: last_pos = text_buf.size() - 1;
      default: last_pos = -1;
    endcase
    foreach (text_buf[i]) send_char(text_buf[i], i == 0, i == last_pos);
    if ($urandom_range(4) == 0) send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_forward_cases();
    wait_quiet();
    write_reg(SCAN_DIR_ADDR, 32'd0);
    send_text("(a+b)", 1'b0);
    send_text("[i]", 1'b0);
    send_text("{x;}", 1'b0);
    send_text(")", 1'b0);
    send_text("(a{", 1'b0);
    send_text("[a;", 1'b0);
    send_text("(]{", 1'b0);
    send_text("(\"a\nb\")", 1'b0);
    send_text("(/*)*/)", 1'b0);
    send_text("(/**/)", 1'b0);
    send_text("(a/b)", 1'b0);
    send_text("(\"\\\")\")", 1'b0);
    send_text("('(')", 1'b0);
    send_text("(ab", 1'b1);
    send_text("(", 1'b1);
    send_char(CH_LROUND, 1'b1, 1'b0);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(CH_RROUND, 1'b0, 1'b0);
    send_char(8'hA5, 1'b0, 1'b1);
    send_text("((", 1'b0);
    send_text("[]", 1'b0);
  endtask

  task automatic test_backward_cases();
    wait_quiet();
    write_reg(SCAN_DIR_ADDR, 32'd1);
    send_text(")a( ", 1'b0);
    send_text(")x\\(y", 1'b0);
    send_text("\\)ab(c", 1'b0);
    send_text(")ab", 1'b1);
    send_text(") /* \\ */ (x", 1'b0);
    send_text("(x", 1'b0);
    send_text(")\"a\"(b", 1'b0);
    send_text("]a[;", 1'b0);
  endtask

  task automatic test_depth_limits();
    wait_quiet();
    write_reg(SCAN_DIR_ADDR, 32'd0);
    send_run(CH_LROUND, MAX_DEPTH_DEFAULT + 1);
  endtask

  task automatic test_receiver_stall();
    src_idle_pct = 0;
    res_idle_pct = 0;
    wait_quiet();
    write_reg(SCAN_DIR_ADDR, 32'd0);
    hold_requests++;
    repeat (40) send_text("()", 1'b0);
  endtask

  task automatic test_random_phase(input int src_pct, input int res_pct);
    int dir0;
    int start;
    src_idle_pct = src_pct;
    res_idle_pct = res_pct;
    dir0 = $urandom_range(0, 1);
    for (int b = 0; b < 5; b++) begin
      wait_quiet();
      write_reg(SCAN_DIR_ADDR, 32'((b + dir0) % 2));
      start = scanned_total;
      while (scanned_total - start < 20) run_random_search();
    end
  endtask

  initial begin
    src_idle_pct = 32;
    res_idle_pct = 74;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_forward_cases();
    test_backward_cases();
    test_depth_limits();
    test_receiver_stall();
    test_random_phase(32, 74);
    test_random_phase(74, 32);
    test_random_phase(0, 0);
    wait_quiet();
    if (errors == 0 && pending_verdicts.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ c_bracket_balance_scanner.f @@
sv/cbb_pkg.sv
sv/cbb_feed.sv
sv/c_bracket_balance_scanner.sv
sv/cbb_checker.sv
tb/sv/tb_c_bracket_balance_scanner.sv
